### design/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property, masked while reset is high
`define WTBCM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wtbcm assertion failed");

// check a property at every edge, reset included
`define WTBCM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wtbcm assertion failed");

`endif

### design/wtbcm_pkg.sv
// Shared types, constants and functions of the wind bucket averager.
// Depends on nothing.
`default_nettype none
package wtbcm_pkg;

  localparam logic [12:0] MAX_BUCKETS = 13'd4096;
  localparam logic [15:0] COUNT_CAP   = 16'hFFFF;

  localparam logic [1:0] CFG_WINDOW_START   = 2'd0;
  localparam logic [1:0] CFG_WINDOW_SECONDS = 2'd1;
  localparam logic [1:0] CFG_MAX_POINTS     = 2'd2;

  localparam logic [16:0] WINDOW_RESET = 17'd3600;
  localparam logic [12:0] POINTS_RESET = 13'd512;

  localparam logic [4:0]  DIV_LAST     = 5'd27;
  localparam logic [4:0]  EMIT_LAST    = 5'd31;
  localparam logic [3:0]  CORDIC_LAST  = 4'd15;

  localparam logic signed [33:0] CORDIC_X0   = 34'sd652032874;
  localparam logic signed [23:0] QUARTER_TURN = 24'sd900000;
  localparam logic signed [23:0] HALF_TURN    = 24'sd1800000;
  localparam logic signed [23:0] THREE_QUARTER = 24'sd2700000;
  localparam logic signed [23:0] FULL_TURN    = 24'sd3600000;
  localparam logic [22:0] RECIP_100 = 23'd5368710;
  localparam logic [16:0] CDEG_TURN = 17'd36000;

  typedef struct packed {
    logic        eos;
    logic [11:0] idx;
    logic [47:0] t;
    logic [15:0] speed;
    logic [15:0] dir;
  } item_t;

  function automatic logic signed [23:0] atan_entry(input logic [3:0] i);
    logic signed [23:0] a;
    case (i)
      4'd0:    a = 24'sd450000;
      4'd1:    a = 24'sd265651;
      4'd2:    a = 24'sd140362;
      4'd3:    a = 24'sd71250;
      4'd4:    a = 24'sd35763;
      4'd5:    a = 24'sd17899;
      4'd6:    a = 24'sd8952;
      4'd7:    a = 24'sd4476;
      4'd8:    a = 24'sd2238;
      4'd9:    a = 24'sd1119;
      4'd10:   a = 24'sd560;
      4'd11:   a = 24'sd280;
      4'd12:   a = 24'sd140;
      4'd13:   a = 24'sd70;
      4'd14:   a = 24'sd35;
      default: a = 24'sd17;
    endcase
    return a;
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] r;
    logic signed [15:0] q;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) begin
      q = 16'sd32767;
    end else if (r < -34'sd32767) begin
      q = -16'sd32767;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

endpackage
`default_nettype wire

### design/wtbcm_if.sv
// Channel interfaces: sample input, result output, configuration writes.
// Depends on nothing.
`default_nettype none
interface wtbcm_sample_if;
  logic        valid;
  logic        ready;
  logic [47:0] sample_time_ms;
  logic [15:0] speed_cms;
  logic [15:0] direction_cdeg;
  logic        end_of_series;
  modport source (output valid, sample_time_ms, speed_cms, direction_cdeg, end_of_series,
                  input ready);
  modport sink (input valid, sample_time_ms, speed_cms, direction_cdeg, end_of_series,
                output ready);
endinterface

interface wtbcm_result_if;
  logic        valid;
  logic        ready;
  logic [47:0] bucket_time_ms;
  logic [15:0] mean_speed_cms;
  logic [15:0] mean_direction_cdeg;
  logic [15:0] sample_count;
  logic        series_done;
  modport source (output valid, bucket_time_ms, mean_speed_cms, mean_direction_cdeg,
                  sample_count, series_done, input ready);
  modport sink (input valid, bucket_time_ms, mean_speed_cms, mean_direction_cdeg,
                sample_count, series_done, output ready);
endinterface

interface wtbcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/wind_time_bucket_circular_mean.sv
// Top level of the wind bucket averager: front end, word queue, back end.
// Depends on wtbcm_pkg, wtbcm_if, wtbcm_front, wtbcm_fifo, wtbcm_back.
//
// Usage: sample words enter on sample_in; each kept sample lands in a time
// bucket. A result word leaves on result_out when a sample opens a different
// (or full) bucket, or when an end_of_series word flushes the open bucket.
// Register writes on cfg are always ready and take effect for later samples.
// The front end takes a new word only after it has passed on or dropped the
// last one; a kept sample runs its 28-step serial bucket divider, and the
// first kept sample after reset or a register write runs it once before that
// to work out the bucket length. The back end takes each sample through its
// 16-step sin/cos CORDIC and then accumulates it; to emit a bucket it runs a
// 32-step mean divider with the atan2 CORDIC alongside, then the centidegree
// scaling. A two-word queue lets both ends stall independently.
// Reset clears all bucket state, restores default registers and empties the
// queue. A stalled receiver holds one result in the output register; the
// back end waits behind it and the queue then backs up into sample_in.
`default_nettype none
module wind_time_bucket_circular_mean (
  input  logic            clk,
  input  logic            rst,
  wtbcm_cfg_if.sink       cfg,
  wtbcm_sample_if.sink    sample_in,
  wtbcm_result_if.source  result_out
);

  logic             q_wr_valid;
  logic             q_wr_ready;
  wtbcm_pkg::item_t q_wr_item;
  logic             q_rd_valid;
  logic             q_rd_ready;
  wtbcm_pkg::item_t q_rd_item;

  wtbcm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .sample_in  (sample_in),
    .push_valid (q_wr_valid),
    .push_ready (q_wr_ready),
    .push_item  (q_wr_item)
  );

  wtbcm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_item  (q_wr_item),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_item  (q_rd_item)
  );

  wtbcm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (q_rd_valid),
    .pop_ready  (q_rd_ready),
    .pop_item   (q_rd_item),
    .result_out (result_out)
  );

endmodule
`default_nettype wire

### design/wtbcm_front.sv
// Front end: config registers, window check and bit-serial bucket divider.
// Depends on wtbcm_pkg and wtbcm_if.
`default_nettype none
module wtbcm_front (
  input  logic               clk,
  input  logic               rst,
  wtbcm_cfg_if.sink          cfg,
  wtbcm_sample_if.sink       sample_in,
  output logic               push_valid,
  input  logic               push_ready,
  output wtbcm_pkg::item_t   push_item
);

  typedef enum logic [1:0] {F_IDLE, F_CHECK, F_DIV, F_PUSH} fstate_t;

  fstate_t          state;
  logic [47:0]      window_start_ms;
  logic [16:0]      window_seconds;
  logic [12:0]      max_points;
  wtbcm_pkg::item_t item;
  logic [27:0]      diff;
  logic [27:0]      bms;
  logic             bms_ok;
  logic             div_bms;
  logic [27:0]      num;
  logic [28:0]      rem;
  logic [27:0]      quo;
  logic [27:0]      den;
  logic [4:0]       cnt;

  logic [12:0] mp;
  logic [11:0] last_idx;
  logic [26:0] span;
  logic [48:0] diff_full;
  logic [48:0] hi;
  logic        below;
  logic        above;
  logic [28:0] rem_sh;
  logic        fits;
  logic [28:0] rem_next;
  logic [27:0] quo_next;
  logic [27:0] bms_q;
  logic [11:0] idx_sel;
  logic        bms_done;

  assign mp        = (max_points > wtbcm_pkg::MAX_BUCKETS) ? wtbcm_pkg::MAX_BUCKETS : max_points;
  assign last_idx  = 12'(mp - 13'd1);
  assign span      = 27'(window_seconds) * 27'd1000;
  assign diff_full = {1'b0, item.t} - {1'b0, window_start_ms};
  assign hi        = {1'b0, window_start_ms} + 49'(span) + 49'd1000;
  assign below     = item.t < window_start_ms;
  assign above     = {1'b0, item.t} > hi;
  assign rem_sh    = {rem[27:0], num[27]};
  assign fits      = rem_sh >= {1'b0, den};
  assign rem_next  = fits ? (rem_sh - {1'b0, den}) : rem_sh;
  assign quo_next  = {quo[26:0], fits};
  assign bms_q     = (quo_next < 28'd1000) ? 28'd1000 : quo_next;
  assign idx_sel   = (quo_next > 28'(last_idx)) ? last_idx : quo_next[11:0];
  assign bms_done  = (state == F_DIV) && (cnt == wtbcm_pkg::DIV_LAST) && div_bms;

  assign sample_in.ready = (state == F_IDLE);
  assign cfg.ready       = 1'b1;
  assign push_valid      = (state == F_PUSH);
  assign push_item       = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= F_IDLE;
      bms_ok          <= 1'b0;
      div_bms         <= 1'b0;
      window_start_ms <= '0;
      window_seconds  <= wtbcm_pkg::WINDOW_RESET;
      max_points      <= wtbcm_pkg::POINTS_RESET;
    end else begin
      case (state)
        F_IDLE: begin
          if (sample_in.valid) begin
            item.eos   <= sample_in.end_of_series;
            item.idx   <= '0;
            item.t     <= sample_in.sample_time_ms;
            item.speed <= sample_in.speed_cms;
            item.dir   <= sample_in.direction_cdeg;
            state      <= F_CHECK;
          end
        end
        F_CHECK: begin
          if (item.eos) begin
            state <= F_PUSH;
          end else if (window_seconds == '0 || mp == '0 || below || above) begin
            state <= F_IDLE;
          end else begin
            diff  <= diff_full[27:0];
            rem   <= '0;
            quo   <= '0;
            cnt   <= '0;
            state <= F_DIV;
            if (bms_ok) begin
              div_bms <= 1'b0;
              num     <= diff_full[27:0];
              den     <= bms;
            end else begin
              div_bms <= 1'b1;
              num     <= 28'(span) + 28'(mp) - 28'd1;
              den     <= 28'(mp);
            end
          end
        end
        F_DIV: begin
          num <= num << 1;
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 5'd1;
          if (cnt == wtbcm_pkg::DIV_LAST) begin
            if (div_bms) begin
              bms     <= bms_q;
              div_bms <= 1'b0;
              num     <= diff;
              den     <= bms_q;
              rem     <= '0;
              quo     <= '0;
              cnt     <= '0;
            end else begin
              item.idx <= idx_sel;
              state    <= F_PUSH;
            end
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
      if (cfg.valid) begin
        bms_ok <= 1'b0;
      end else if (bms_done) begin
        bms_ok <= 1'b1;
      end
      if (cfg.valid) begin
        case (cfg.index)
          wtbcm_pkg::CFG_WINDOW_START: begin
            window_start_ms <= cfg.data;
          end
          wtbcm_pkg::CFG_WINDOW_SECONDS: begin
            window_seconds <= cfg.data[16:0];
          end
          wtbcm_pkg::CFG_MAX_POINTS: begin
            max_points <= cfg.data[12:0];
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

### design/wtbcm_fifo.sv
// Two-entry word queue between front end and back end.
// Depends on wtbcm_pkg.
`default_nettype none
module wtbcm_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  wtbcm_pkg::item_t wr_item,
  output logic             rd_valid,
  input  logic             rd_ready,
  output wtbcm_pkg::item_t rd_item
);

  wtbcm_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule
`default_nettype wire

### design/wtbcm_back.sv
// Back end: sin/cos CORDIC, bucket accumulators, mean divider, atan2 CORDIC.
// Depends on wtbcm_pkg and wtbcm_if.
`default_nettype none
module wtbcm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  wtbcm_pkg::item_t pop_item,
  wtbcm_result_if.source   result_out
);

  typedef enum logic [2:0] {B_IDLE, B_SINCOS, B_ACCUM, B_EMIT, B_DIVQ, B_OUT} bstate_t;

  bstate_t            state;
  wtbcm_pkg::item_t   cur;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [23:0] cz;
  logic               cneg;
  logic [3:0]         step;

  logic               bucket_open;
  logic [11:0]        open_bucket_index;
  logic [47:0]        last_sample_time;
  logic [31:0]        speed_accumulator;
  logic signed [32:0] sine_accumulator;
  logic signed [32:0] cosine_accumulator;
  logic [15:0]        samples_in_bucket;

  logic [47:0]        e_time;
  logic [15:0]        e_count;
  logic               e_done;
  logic [31:0]        dnum;
  logic [16:0]        drem;
  logic [31:0]        dquo;
  logic signed [51:0] vx;
  logic signed [51:0] vy;
  logic signed [23:0] vz;
  logic               vzero;
  logic [4:0]         ecnt;
  logic [45:0]        prod;

  logic               out_valid;
  logic [47:0]        out_time;
  logic [15:0]        out_speed;
  logic [15:0]        out_dir;
  logic [15:0]        out_count;
  logic               out_done;

  logic [15:0]        dir_m;
  logic signed [23:0] z100;
  logic signed [23:0] z_red;
  logic               neg_red;
  logic signed [33:0] sdx;
  logic signed [33:0] sdy;
  logic signed [23:0] s_atan;
  logic signed [15:0] s_q15;
  logic signed [15:0] c_q15;
  logic signed [51:0] cs_ext;
  logic signed [51:0] sn_ext;
  logic               vneg0;
  logic signed [51:0] vdx;
  logic signed [51:0] vdy;
  logic signed [23:0] v_atan;
  logic [16:0]        drem_sh;
  logic               dfits;
  logic signed [23:0] vz_wrap;
  logic [22:0]        cd_num;
  logic [16:0]        cd_q;
  logic               need_emit;
  logic               out_load;

  assign dir_m   = (pop_item.dir >= 16'(wtbcm_pkg::CDEG_TURN))
                   ? (pop_item.dir - 16'(wtbcm_pkg::CDEG_TURN)) : pop_item.dir;
  assign z100    = 24'(dir_m) * 24'sd100;
  assign neg_red = (z100 > wtbcm_pkg::QUARTER_TURN) && (z100 < wtbcm_pkg::THREE_QUARTER);
  assign z_red   = neg_red ? (z100 - wtbcm_pkg::HALF_TURN)
                 : (z100 >= wtbcm_pkg::THREE_QUARTER) ? (z100 - wtbcm_pkg::FULL_TURN) : z100;

  assign sdx    = cy >>> step;
  assign sdy    = cx >>> step;
  assign s_atan = wtbcm_pkg::atan_entry(step);
  assign s_q15  = wtbcm_pkg::to_q15(cneg ? -cy : cy);
  assign c_q15  = wtbcm_pkg::to_q15(cneg ? -cx : cx);

  assign cs_ext = 52'(cosine_accumulator) <<< 16;
  assign sn_ext = 52'(sine_accumulator) <<< 16;
  assign vneg0  = cosine_accumulator < 0;

  assign vdx    = vy >>> ecnt[3:0];
  assign vdy    = vx >>> ecnt[3:0];
  assign v_atan = wtbcm_pkg::atan_entry(ecnt[3:0]);

  assign drem_sh = {drem[15:0], dnum[31]};
  assign dfits   = drem_sh >= {1'b0, e_count};

  assign vz_wrap = (vz < 0) ? (vz + wtbcm_pkg::FULL_TURN)
                 : (vz >= wtbcm_pkg::FULL_TURN) ? (vz - wtbcm_pkg::FULL_TURN) : vz;
  assign cd_num  = 23'(vz_wrap) + 23'd50;
  assign cd_q    = prod[45:29];

  assign need_emit = bucket_open && (cur.idx != open_bucket_index ||
                                     samples_in_bucket == wtbcm_pkg::COUNT_CAP);
  assign out_load  = (state == B_OUT) && (!out_valid || result_out.ready);

  assign pop_ready                  = (state == B_IDLE);
  assign result_out.valid           = out_valid;
  assign result_out.bucket_time_ms  = out_time;
  assign result_out.mean_speed_cms  = out_speed;
  assign result_out.mean_direction_cdeg = out_dir;
  assign result_out.sample_count    = out_count;
  assign result_out.series_done     = out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= B_IDLE;
      out_valid          <= 1'b0;
      bucket_open        <= 1'b0;
      open_bucket_index  <= '0;
      last_sample_time   <= '0;
      speed_accumulator  <= '0;
      sine_accumulator   <= '0;
      cosine_accumulator <= '0;
      samples_in_bucket  <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            cur <= pop_item;
            if (pop_item.eos) begin
              if (bucket_open) begin
                e_time <= last_sample_time;
                e_count <= samples_in_bucket;
                e_done <= 1'b1;
                dnum   <= speed_accumulator;
                drem   <= '0;
                dquo   <= '0;
                vzero  <= (sine_accumulator == 0) && (cosine_accumulator == 0);
                vx     <= vneg0 ? -cs_ext : cs_ext;
                vy     <= vneg0 ? -sn_ext : sn_ext;
                vz     <= vneg0 ? wtbcm_pkg::HALF_TURN : 24'sd0;
                ecnt   <= '0;
                state  <= B_EMIT;
              end
              bucket_open        <= 1'b0;
              open_bucket_index  <= '0;
              last_sample_time   <= '0;
              speed_accumulator  <= '0;
              sine_accumulator   <= '0;
              cosine_accumulator <= '0;
              samples_in_bucket  <= '0;
            end else begin
              cx    <= wtbcm_pkg::CORDIC_X0;
              cy    <= '0;
              cz    <= z_red;
              cneg  <= neg_red;
              step  <= '0;
              state <= B_SINCOS;
            end
          end
        end
        B_SINCOS: begin
          if (cz >= 0) begin
            cx <= cx - sdx;
            cy <= cy + sdy;
            cz <= cz - s_atan;
          end else begin
            cx <= cx + sdx;
            cy <= cy - sdy;
            cz <= cz + s_atan;
          end
          step <= step + 4'd1;
          if (step == wtbcm_pkg::CORDIC_LAST) begin
            state <= B_ACCUM;
          end
        end
        B_ACCUM: begin
          bucket_open       <= 1'b1;
          open_bucket_index <= cur.idx;
          last_sample_time  <= cur.t;
          if (need_emit) begin
            e_time  <= last_sample_time;
            e_count <= samples_in_bucket;
            e_done  <= 1'b0;
            dnum    <= speed_accumulator;
            drem    <= '0;
            dquo    <= '0;
            vzero   <= (sine_accumulator == 0) && (cosine_accumulator == 0);
            vx      <= vneg0 ? -cs_ext : cs_ext;
            vy      <= vneg0 ? -sn_ext : sn_ext;
            vz      <= vneg0 ? wtbcm_pkg::HALF_TURN : 24'sd0;
            ecnt    <= '0;
            speed_accumulator  <= 32'(cur.speed);
            sine_accumulator   <= 33'(s_q15);
            cosine_accumulator <= 33'(c_q15);
            samples_in_bucket  <= 16'd1;
            state <= B_EMIT;
          end else begin
            speed_accumulator  <= speed_accumulator + 32'(cur.speed);
            sine_accumulator   <= sine_accumulator + 33'(s_q15);
            cosine_accumulator <= cosine_accumulator + 33'(c_q15);
            samples_in_bucket  <= samples_in_bucket + 16'd1;
            state <= B_IDLE;
          end
        end
        B_EMIT: begin
          dnum <= dnum << 1;
          drem <= dfits ? (drem_sh - {1'b0, e_count}) : drem_sh;
          dquo <= {dquo[30:0], dfits};
          if (!ecnt[4]) begin
            if (vy > 0) begin
              vx <= vx + vdx;
              vy <= vy - vdy;
              vz <= vz + v_atan;
            end else begin
              vx <= vx - vdx;
              vy <= vy + vdy;
              vz <= vz - v_atan;
            end
          end
          ecnt <= ecnt + 5'd1;
          if (ecnt == wtbcm_pkg::EMIT_LAST) begin
            state <= B_DIVQ;
          end
        end
        B_DIVQ: begin
          prod  <= 46'(cd_num) * 46'(wtbcm_pkg::RECIP_100);
          state <= B_OUT;
        end
        B_OUT: begin
          if (out_load) begin
            out_time  <= e_time;
            out_speed <= dquo[15:0];
            out_dir   <= (vzero || cd_q >= wtbcm_pkg::CDEG_TURN) ? 16'd0 : cd_q[15:0];
            out_count <= e_count;
            out_done  <= e_done;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/wtbcm_checker.sv
// Port-level checks on the result channel of the wind bucket averager.
// Depends on assert_macros.svh; bound to wind_time_bucket_circular_mean.
`default_nettype none
`include "assert_macros.svh"
module wtbcm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_time,
  input logic [15:0] out_speed,
  input logic [15:0] out_dir,
  input logic [15:0] out_count,
  input logic        out_done
);

  `WTBCM_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid)
  `WTBCM_ASSERT(a_hold_stalled, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_time) && $stable(out_speed) && $stable(out_dir) && $stable(out_count) && $stable(out_done))
  `WTBCM_ASSERT(a_count_nonzero, clk, rst, out_valid |-> out_count != 16'd0)
  `WTBCM_ASSERT(a_dir_in_range, clk, rst, out_valid |-> out_dir < 16'd36000)

endmodule

bind wind_time_bucket_circular_mean wtbcm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .out_time  (result_out.bucket_time_ms),
  .out_speed (result_out.mean_speed_cms),
  .out_dir   (result_out.mean_direction_cdeg),
  .out_count (result_out.sample_count),
  .out_done  (result_out.series_done)
);
`default_nettype wire

### verif/tb_top.sv
// Testbench for the wind bucket averager: directed table, register extremes, then random series.
// Depends on wtbcm_pkg, wtbcm_if and the wind_time_bucket_circular_mean RTL.
`default_nettype none
module tb_top;

  typedef struct {
    logic [47:0] t;
    logic [15:0] speed;
    logic [15:0] dir;
    logic        eos;
  } sample_word_t;

  typedef struct {
    logic [47:0] t;
    logic [15:0] speed;
    logic [15:0] dir;
    logic [15:0] count;
    logic        done;
  } bucket_word_t;

  typedef struct {
    sample_word_t w;
    bit           fixed;
    bucket_word_t r;
  } table_row_t;

  logic clk;
  logic rst;
  wtbcm_cfg_if    cfg();
  wtbcm_sample_if smp();
  wtbcm_result_if res();

  wind_time_bucket_circular_mean uut (
    .clk(clk), .rst(rst), .cfg(cfg), .sample_in(smp), .result_out(res)
  );

  // predictor state
  logic [47:0] m_start;
  logic [16:0] m_window;
  logic [12:0] m_points;
  bit          m_open;
  logic [11:0] m_idx;
  logic [47:0] m_last;
  logic [31:0] m_speed_sum;
  longint      m_sin_sum;
  longint      m_cos_sum;
  logic [15:0] m_count;

  bucket_word_t expected_buckets[$];
  bit           fixed_flags[$];
  bucket_word_t fixed_words[$];
  int errors;
  int idle_cycles;
  bit ready_hold;

  const longint atan_steps[16] = '{450000, 265651, 140362, 71250, 35763, 17899,
    8952, 4476, 2238, 1119, 560, 280, 140, 70, 35, 17};

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q15_of(longint v);
    longint r;
    r = floor_shift(v + 16384, 15);
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r;
  endfunction

  task automatic trig_of(input logic [15:0] cdeg, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit neg;
    z = longint'(cdeg % 36000) * 100;
    x = 652032874;
    y = 0;
    neg = 0;
    if (z > 900000 && z < 2700000) begin
      z -= 1800000;
      neg = 1;
    end else if (z >= 2700000) begin
      z -= 3600000;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_steps[i];
      end else begin
        x += dx; y -= dy; z += atan_steps[i];
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    s = q15_of(y);
    c = q15_of(x);
  endtask

  function automatic logic [15:0] heading_of(longint ssum, longint csum);
    longint x, y, z, dx, dy, cd;
    if (ssum == 0 && csum == 0) return 0;
    x = csum * 65536;
    y = ssum * 65536;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 1800000;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_steps[i];
      end else begin
        x -= dx; y += dy; z -= atan_steps[i];
      end
    end
    while (z < 0) z += 3600000;
    while (z >= 3600000) z -= 3600000;
    cd = (z + 50) / 100;
    if (cd >= 36000) cd = 0;
    return cd[15:0];
  endfunction

  function automatic bucket_word_t close_bucket(bit done);
    bucket_word_t b;
    b.t = m_last;
    b.speed = m_speed_sum / ((m_count == 0) ? 32'd1 : 32'(m_count));
    b.dir = heading_of(m_sin_sum, m_cos_sum);
    b.count = m_count;
    b.done = done;
    return b;
  endfunction

  function automatic void clear_bucket_model();
    m_open = 0; m_idx = 0; m_last = 0; m_speed_sum = 0;
    m_sin_sum = 0; m_cos_sum = 0; m_count = 0;
  endfunction

  // sets emitted to 1 when the word closes a bucket
  task automatic predict_bucket(input sample_word_t w, output bit emitted,
                                output bucket_word_t b);
    longint unsigned mp, span, bms, idx;
    longint s, c;
    emitted = 0;
    if (w.eos) begin
      if (m_open) begin
        b = close_bucket(1);
        emitted = 1;
      end
      clear_bucket_model();
      return;
    end
    mp = (m_points > 4096) ? 4096 : m_points;
    if (m_window == 0 || mp == 0) return;
    span = longint'(m_window) * 1000;
    if (w.t < m_start || 64'(w.t) > 64'(m_start) + span + 1000) return;
    bms = (span + mp - 1) / mp;
    if (bms < 1000) bms = 1000;
    idx = (w.t - m_start) / bms;
    if (idx > mp - 1) idx = mp - 1;
    if (m_open && (idx[11:0] != m_idx || m_count >= wtbcm_pkg::COUNT_CAP)) begin
      b = close_bucket(0);
      emitted = 1;
      clear_bucket_model();
    end
    trig_of(w.dir, s, c);
    m_open = 1;
    m_idx = idx[11:0];
    m_last = w.t;
    m_speed_sum += w.speed;
    m_sin_sum += s;
    m_cos_sum += c;
    m_count++;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
    case (idx)
      wtbcm_pkg::CFG_WINDOW_START:   m_start = value;
      wtbcm_pkg::CFG_WINDOW_SECONDS: m_window = value[16:0];
      default:                       m_points = value[12:0];
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_buckets.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return;
    if (r < 95) repeat ($urandom_range(1, 4)) @(posedge clk);
    else repeat ($urandom_range(20, 120)) @(posedge clk);
  endtask

  task automatic send_word(input sample_word_t w, input bit fixed, input bucket_word_t fw);
    bit hit;
    bucket_word_t b;
    smp.valid <= 1;
    smp.sample_time_ms <= w.t;
    smp.speed_cms <= w.speed;
    smp.direction_cdeg <= w.dir;
    smp.end_of_series <= w.eos;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    predict_bucket(w, hit, b);
    if (hit) begin
      expected_buckets.push_back(b);
      fixed_flags.push_back(fixed);
      fixed_words.push_back(fw);
    end
    smp.valid <= 0;
    @(posedge clk);
  endtask

  // check results
  always @(posedge clk) begin
    bucket_word_t e, f;
    bit fx;
    if (!rst && res.valid && res.ready) begin
      if (expected_buckets.size() == 0) begin
        report("unexpected bucket", res.bucket_time_ms, 0);
      end else begin
        e = expected_buckets.pop_front();
        fx = fixed_flags.pop_front();
        f = fixed_words.pop_front();
        if (fx) e = f;
        if (res.bucket_time_ms !== e.t) report("bucket_time_ms", res.bucket_time_ms, e.t);
        if (res.mean_speed_cms !== e.speed) report("mean_speed_cms", res.mean_speed_cms, e.speed);
        if (res.mean_direction_cdeg !== e.dir)
          report("mean_direction_cdeg", res.mean_direction_cdeg, e.dir);
        if (res.sample_count !== e.count) report("sample_count", res.sample_count, e.count);
        if (res.series_done !== e.done) report("series_done", res.series_done, e.done);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    int r;
    if (rst) begin
      res.ready <= 1;
    end else if (ready_hold) begin
      res.ready <= 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) res.ready <= 1;
      else if (r < 98) res.ready <= 0;
      else begin
        res.ready <= 0;
        repeat ($urandom_range(20, 150)) @(posedge clk);
        res.ready <= 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("wind_time_bucket_circular_mean regression: fail");
      $finish;
    end
  end

  function automatic sample_word_t mk(logic [47:0] t, logic [15:0] s, logic [15:0] d, logic e);
    sample_word_t w;
    w.t = t; w.speed = s; w.dir = d; w.eos = e;
    return w;
  endfunction

  function automatic bucket_word_t mkb(logic [47:0] t, logic [15:0] s, logic [15:0] d,
                                       logic [15:0] n, logic e);
    bucket_word_t b;
    b.t = t; b.speed = s; b.dir = d; b.count = n; b.done = e;
    return b;
  endfunction

  initial begin
    table_row_t rows[$];
    bucket_word_t none;
    longint unsigned t_now, step, base;
    int n_series, len;
    none = mkb(0, 0, 0, 0, 0);
    rst = 1;
    cfg.valid = 0; cfg.index = wtbcm_pkg::CFG_WINDOW_START; cfg.data = 0;
    smp.valid = 0; smp.sample_time_ms = 0; smp.speed_cms = 0;
    smp.direction_cdeg = 0; smp.end_of_series = 0;
    m_start = 0; m_window = wtbcm_pkg::WINDOW_RESET; m_points = wtbcm_pkg::POINTS_RESET;
    clear_bucket_model();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset registers: bucket length 7032 ms
    rows.push_back('{mk(0, 65535, 0, 0), 1'b0, none});
    rows.push_back('{mk(100, 0, 9000, 0), 1'b0, none});
    rows.push_back('{mk(7032, 5, 18000, 0), 1'b1, mkb(100, 32767, 4500, 2, 0)});
    rows.push_back('{mk(0, 0, 0, 1), 1'b1, mkb(7032, 5, 18000, 1, 1)});
    rows.push_back('{mk(0, 0, 0, 1), 1'b0, none});
    rows.push_back('{mk(1000, 10, 0, 0), 1'b0, none});
    rows.push_back('{mk(1001, 10, 18000, 0), 1'b0, none});
    rows.push_back('{mk(0, 0, 0, 1), 1'b1, mkb(1001, 10, 0, 2, 1)});
    rows.push_back('{mk(3601000, 1, 35999, 0), 1'b0, none});
    rows.push_back('{mk(3601001, 1, 65535, 0), 1'b0, none});
    rows.push_back('{mk(48'hFFFF_FFFF_FFFF, 1, 27000, 0), 1'b0, none});
    rows.push_back('{mk(5000, 7, 27000, 0), 1'b0, none});
    rows.push_back('{mk(0, 0, 0, 1), 1'b0, none});
    rows.push_back('{mk(0, 0, 0, 1), 1'b0, none});
    foreach (rows[i]) begin
      send_word(rows[i].w, rows[i].fixed, rows[i].r);
      random_gap();
    end
    drain();

    // extremes of the registers
    write_reg(wtbcm_pkg::CFG_WINDOW_START, 48'hFFFF_FFFF_0000);
    write_reg(wtbcm_pkg::CFG_WINDOW_SECONDS, 17'h1FFFF);
    write_reg(wtbcm_pkg::CFG_MAX_POINTS, 13'h1FFF);
    send_word(mk(48'hFFFF_FFFF_0000, 3, 100, 0), 0, none);
    send_word(mk(48'hFFFF_FFFF_FFFF, 4, 200, 0), 0, none);
    send_word(mk(48'hFFFF_FFFE_FFFF, 4, 200, 0), 0, none);
    send_word(mk(0, 0, 0, 1), 0, none);
    drain();
    write_reg(wtbcm_pkg::CFG_WINDOW_SECONDS, 0);
    send_word(mk(48'hFFFF_FFFF_1000, 3, 100, 0), 0, none);
    write_reg(wtbcm_pkg::CFG_WINDOW_SECONDS, 1);
    write_reg(wtbcm_pkg::CFG_MAX_POINTS, 0);
    send_word(mk(48'hFFFF_FFFF_1000, 3, 100, 0), 0, none);
    send_word(mk(0, 0, 0, 1), 0, none);
    drain();

    // random series under a handful of settings
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(wtbcm_pkg::CFG_WINDOW_START, (phase == 7) ? 48'hFFFF_FFF0_0000 :
                48'($urandom_range(0, 1000000)) << $urandom_range(0, 20));
      write_reg(wtbcm_pkg::CFG_WINDOW_SECONDS, (phase == 1) ? 17'd86400 :
                (phase == 2) ? 17'd1 : 17'($urandom_range(1, 300)));
      write_reg(wtbcm_pkg::CFG_MAX_POINTS, (phase == 3) ? 13'd4096 : (phase == 4) ? 13'd1 :
                (phase == 5) ? 13'h1FFF : 13'($urandom_range(1, 64)));
      n_series = 0;
      for (int k = 0; k < 240; k++) begin
        if (n_series == 0) begin
          t_now = m_start;
          if ($urandom_range(0, 9) == 0 && m_start > 2000)
            t_now = m_start - $urandom_range(1, 2000);
          len = $urandom_range(3, 60);
          n_series = len;
          step = (64'(m_window) * 1000 + 2000) / len + 1;
        end
        if ($urandom_range(0, 29) == 0) begin
          send_word(mk(48'({$urandom, $urandom}), 16'($urandom), 16'($urandom),
                       1'($urandom)), 0, none);
        end else if (n_series == 1) begin
          send_word(mk(48'({$urandom, $urandom}), 16'($urandom), 16'($urandom), 1), 0, none);
        end else begin
          base = t_now;
          send_word(mk(48'(base), 16'($urandom),
                       ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                       16'($urandom_range(0, 35999)), 0), 0, none);
          t_now = t_now + $urandom_range(0, 32'(2 * step));
          if ($urandom_range(0, 39) == 0 && t_now > 5000) t_now -= $urandom_range(0, 5000);
        end
        n_series--;
        if (phase == 4 && k == 100) begin
          while (expected_buckets.size() != 0) @(posedge clk);
        end
        if (phase == 6 && k < 60) ready_hold = 1;
        else ready_hold = 0;
        random_gap();
      end
      send_word(mk(0, 0, 0, 1), 0, none);
      drain();
    end

    if (errors == 0)
      $display("wind_time_bucket_circular_mean regression: pass");
    else
      $display("wind_time_bucket_circular_mean regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
+incdir+design
design/wtbcm_pkg.sv
design/wtbcm_if.sv
design/wtbcm_front.sv
design/wtbcm_fifo.sv
design/wtbcm_back.sv
design/wind_time_bucket_circular_mean.sv
design/wtbcm_checker.sv
verif/tb_top.sv
